// File: src/abc_pkg.sv
// Shared types and constants for the accelerometer bias calibrator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package abc_pkg;

  localparam int AXES      = 6;
  localparam int AXIS_W    = $clog2(AXES);
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 34;
  localparam int OUT_W     = 18;
  localparam int CNT_W     = 16;
  localparam int GRAV_W    = 15;
  localparam int OP_W      = 2;

  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(628);  // 9.81 * 64

  localparam int MAX_SAMPLES_DEF = 65535;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd0;
  localparam logic [OP_W-1:0] OP_APPLY     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_FIRST_ROLL  = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_SECOND_ROLL = AXIS_W'(3);

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;  // two's complement
    logic [CNT_W-1:0] divisor;   // never zero when started
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;      // low bits of the signed quotient
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/abc_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on abc_pkg for field widths.
`default_nettype none

interface abc_item_if;
  import abc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [SAMPLE_W-1:0] first_roll;
  logic signed [SAMPLE_W-1:0] first_pitch;
  logic signed [SAMPLE_W-1:0] first_yaw;
  logic signed [SAMPLE_W-1:0] second_roll;
  logic signed [SAMPLE_W-1:0] second_pitch;
  logic signed [SAMPLE_W-1:0] second_yaw;

  modport source (
    output valid, operation, first_roll, first_pitch, first_yaw,
           second_roll, second_pitch, second_yaw,
    input  ready
  );

  modport sink (
    input  valid, operation, first_roll, first_pitch, first_yaw,
           second_roll, second_pitch, second_yaw,
    output ready
  );
endinterface

interface abc_result_if;
  import abc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_first_roll;
  logic signed [OUT_W-1:0] out_first_pitch;
  logic signed [OUT_W-1:0] out_first_yaw;
  logic signed [OUT_W-1:0] out_second_roll;
  logic signed [OUT_W-1:0] out_second_pitch;
  logic signed [OUT_W-1:0] out_second_yaw;
  logic [CNT_W-1:0]        samples_taken;

  modport source (
    output valid, out_first_roll, out_first_pitch, out_first_yaw,
           out_second_roll, out_second_pitch, out_second_yaw, samples_taken,
    input  ready
  );

  modport sink (
    input  valid, out_first_roll, out_first_pitch, out_first_yaw,
           out_second_roll, out_second_pitch, out_second_yaw, samples_taken,
    output ready
  );
endinterface

`default_nettype wire

// File: src/abc_div.sv
// Bit-serial restoring divider: signed running sum over unsigned sample count,
// truncated toward zero, one quotient bit per cycle. Depends on abc_pkg.
`default_nettype none

module abc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abc_pkg::div_req_t req_i,
  output abc_pkg::div_rsp_t rsp_o
);
  import abc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [SUM_W-1:0]  quo_q;   // dividend bits shift out, quotient bits shift in

  logic [SUM_W-1:0]  mag;
  logic [CNT_W+1:0]  diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_d;

  assign mag   = req_i.dividend[SUM_W-1] ? (~req_i.dividend + SUM_W'(1)) : req_i.dividend;
  assign diff  = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, dvs_q};
  assign ge    = ~diff[CNT_W+1];
  assign rem_d = ge ? diff[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[SUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (step_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.dividend[SUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (~quo_q[OUT_W-1:0] + OUT_W'(1)) : quo_q[OUT_W-1:0];

endmodule

`default_nettype wire

// File: src/accel_bias_calibrator.sv
// Six-axis accelerometer bias calibrator; uses abc_pkg, abc_if and abc_div.
// Calibrate below the count limit runs six 34-step serial divisions, one per
// axis; apply, saturated calibrate, clear or reserved run no division. One item
// at a time; the result register frees the input side while a result waits.
// Reset clears sums, biases, count at once through per-entry valid bits and
// loads gravity_offset with 628.
`default_nettype none

module accel_bias_calibrator #(
  parameter int MAX_SAMPLES = abc_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = abc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        gravity_offset_we_i,
  input  logic [abc_pkg::GRAV_W-1:0]  gravity_offset_i,
  abc_item_if.sink                    item_i,
  abc_result_if.source                result_o
);
  import abc_pkg::*;

  localparam int  KEEP     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam bit  SIGN_EXT = (SAMPLE_BITS <= SAMPLE_W);
  localparam int  ENTRY_W  = SUM_W + OUT_W;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StDiv,
    StFinish
  } state_e;

  // take the low SAMPLE_BITS as two's complement (SAMPLE_BITS above SAMPLE_W: all bits, zero-extended)
  function automatic logic [SUM_W-1:0] ext_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SUM_W-1:0] v;
    logic             fill;
    fill = SIGN_EXT ? raw[KEEP-1] : 1'b0;
    for (int b = 0; b < SAMPLE_W; b++) begin
      v[b] = (b < KEEP) ? raw[b] : fill;
    end
    for (int b = SAMPLE_W; b < SUM_W; b++) begin
      v[b] = fill;
    end
    return v;
  endfunction

  state_e              state_q;
  logic [GRAV_W-1:0]   gravity_q;
  logic [CNT_W-1:0]    count_q;
  logic [AXES-1:0]     valid_q;
  logic [AXIS_W-1:0]   axis_q;
  logic                update_q;
  logic                apply_q;
  logic [SAMPLE_W-1:0] samples_q [AXES];
  logic [OUT_W-1:0]    res_q [AXES];
  logic [SUM_W-1:0]    newsum_q;

  // sum/bias store, one entry per axis, registered read
  logic [ENTRY_W-1:0]  mem_q [AXES];
  logic [ENTRY_W-1:0]  rdata_q;
  logic                rd_valid_q;

  logic                out_valid_q;
  logic [OUT_W-1:0]    out_q [AXES];
  logic [CNT_W-1:0]    out_cnt_q;

  logic                item_acc;
  logic [SUM_W-1:0]    rd_sum;
  logic [OUT_W-1:0]    rd_bias;
  logic [SUM_W-1:0]    smp;
  logic [SUM_W-1:0]    addend;
  logic [SUM_W-1:0]    newsum_d;
  logic [SUM_W-1:0]    applied;
  logic                is_roll;
  logic                last_axis;
  logic                out_free;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign item_i.ready = (state_q == StIdle);
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  assign rd_sum    = rd_valid_q ? rdata_q[ENTRY_W-1:OUT_W] : '0;
  assign rd_bias   = rd_valid_q ? rdata_q[OUT_W-1:0] : '0;
  assign smp       = ext_sample(samples_q[axis_q]);
  assign is_roll   = (axis_q == AXIS_FIRST_ROLL) || (axis_q == AXIS_SECOND_ROLL);
  assign addend    = is_roll ? (smp - {{(SUM_W-GRAV_W){1'b0}}, gravity_q}) : smp;
  assign newsum_d  = rd_sum + addend;
  assign applied   = smp - {{(SUM_W-OUT_W){rd_bias[OUT_W-1]}}, rd_bias};
  assign last_axis = (axis_q == AXIS_W'(AXES - 1));

  assign div_req.start    = (state_q == StExec) && update_q;
  assign div_req.dividend = newsum_d;
  assign div_req.divisor  = count_q;

  abc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAV_RESET;
    end else if (gravity_offset_we_i) begin
      gravity_q <= gravity_offset_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      samples_q[0] <= item_i.first_roll;
      samples_q[1] <= item_i.first_pitch;
      samples_q[2] <= item_i.first_yaw;
      samples_q[3] <= item_i.second_roll;
      samples_q[4] <= item_i.second_pitch;
      samples_q[5] <= item_i.second_yaw;
    end
  end

  // Each axis is read, and any update written back, before the next read, so
  // accesses to one entry never overlap.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      rdata_q    <= mem_q[axis_q];
      rd_valid_q <= valid_q[axis_q];
    end
    if ((state_q == StDiv) && div_rsp.done) begin
      mem_q[axis_q] <= {newsum_q, div_rsp.quot};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      valid_q     <= '0;
      axis_q      <= '0;
      update_q    <= 1'b0;
      apply_q     <= 1'b0;
      newsum_q    <= '0;
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
      for (int a = 0; a < AXES; a++) begin
        res_q[a] <= '0;
        out_q[a] <= '0;
      end
    end else begin
      // in StFinish the register is reloaded below whenever it drains
      if (out_valid_q && result_o.ready && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (item_acc) begin
            axis_q   <= '0;
            update_q <= (item_i.operation == OP_CALIBRATE) &&
                        (count_q < CNT_W'(MAX_SAMPLES));
            apply_q  <= (item_i.operation == OP_APPLY);
            case (item_i.operation)
              OP_CALIBRATE: begin
                if (count_q < CNT_W'(MAX_SAMPLES)) begin
                  count_q <= count_q + CNT_W'(1);
                end
                state_q <= StRead;
              end
              OP_APPLY: begin
                state_q <= StRead;
              end
              OP_CLEAR: begin
                count_q <= '0;
                valid_q <= '0;
                for (int a = 0; a < AXES; a++) res_q[a] <= '0;
                state_q <= StFinish;
              end
              default: begin
                for (int a = 0; a < AXES; a++) res_q[a] <= '0;
                state_q <= StFinish;
              end
            endcase
          end
        end
        StRead: begin
          state_q <= StExec;
        end
        StExec: begin
          if (update_q) begin
            newsum_q <= newsum_d;
            state_q  <= StDiv;
          end else begin
            res_q[axis_q] <= apply_q ? applied[OUT_W-1:0] : rd_bias;
            axis_q        <= axis_q + AXIS_W'(1);
            state_q       <= last_axis ? StFinish : StRead;
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            res_q[axis_q]   <= div_rsp.quot;
            valid_q[axis_q] <= 1'b1;
            axis_q          <= axis_q + AXIS_W'(1);
            state_q         <= last_axis ? StFinish : StRead;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cnt_q   <= count_q;
            for (int a = 0; a < AXES; a++) out_q[a] <= res_q[a];
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.out_first_roll   = out_q[0];
  assign result_o.out_first_pitch  = out_q[1];
  assign result_o.out_first_yaw    = out_q[2];
  assign result_o.out_second_roll  = out_q[3];
  assign result_o.out_second_pitch = out_q[4];
  assign result_o.out_second_yaw   = out_q[5];
  assign result_o.samples_taken    = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above limit");

  a_count_on_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(item_acc))
    else $error("sample count moved without an accepted beat");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc && (item_i.operation == OP_CLEAR)) |=> (valid_q == '0) && (count_q == '0))
    else $error("clear left state behind");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire
